// ===== rtl/double_ended_queue_assert.svh =====
// ----------------------------------------------------------------------------
// double_ended_queue_assert.svh
// Assertion macros used by the checker file of the deque block.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// ante holds at a clock edge, so cons must hold at the same edge
`define DEQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed: same-cycle implication");

// ante holds at a clock edge, so cons must hold at the next edge
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed: next-cycle implication");

`endif

// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Types, constants and ring arithmetic for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH      = 1024;
   localparam int DATA_WIDTH = 32;

   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W   = ADDR_W + 1;
   localparam int FIELD_W = 11;
   localparam int CMP_W   = (COUNT_W > FIELD_W) ? COUNT_W : FIELD_W;

   // opcodes
   localparam logic [2:0] OP_PUSH_REAR  = 3'd0;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_REAR   = 3'd3;
   localparam logic [2:0] OP_READ_POS   = 3'd4;
   localparam logic [2:0] OP_DROP       = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] value;
      logic [10:0]        position;
      logic [10:0]        remove_count;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         status;
      logic [10:0]        fill_level;
   } rsp_type;

   // control handed from the request stage to the result stage
   typedef struct packed {
      logic        valid;
      logic        from_mem;
      logic [1:0]  status;
      logic [10:0] fill;
   } rsp_ctl_type;

   // (base + off) mod DEPTH; base < DEPTH and off <= DEPTH
   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                  input logic [SUM_W-1:0]  off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + off;
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   // input word to stored word: low DATA_WIDTH bits, zero extended
   function automatic logic [DATA_WIDTH-1:0] to_word(input logic signed [31:0] v);
      logic [63:0] t;
      t = {32'b0, v};
      return t[DATA_WIDTH-1:0];
   endfunction

   // stored word to 32-bit result, sign extended
   function automatic logic signed [31:0] from_word(input logic signed [DATA_WIDTH-1:0] w);
      logic [63:0] t;
      t = 64'(w);
      return t[31:0];
   endfunction

endpackage

// ===== rtl/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WORDS  = 1024,
   parameter int DATA_W = 32,
   parameter int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end else begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Front/count bookkeeping; issues at most one RAM access per accepted beat.
// ----------------------------------------------------------------------------
module deq_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  deq_pkg::req_type                req,
   output logic                            mem_wr_en,
   output logic [deq_pkg::ADDR_W-1:0]      mem_addr,
   output logic [deq_pkg::DATA_WIDTH-1:0]  mem_wr_data,
   output deq_pkg::rsp_ctl_type            rsp_ctl
);

   logic [deq_pkg::ADDR_W-1:0]  front_ff,  front_in;
   logic [deq_pkg::COUNT_W-1:0] count_ff,  count_in;
   deq_pkg::rsp_ctl_type        rsp_ctl_ff, rsp_ctl_in;

   logic [deq_pkg::CMP_W-1:0]   cnt_x, pos_x, k_x;
   logic [deq_pkg::COUNT_W-1:0] k_eff;
   logic                        full, empty, pos_ok;
   logic [deq_pkg::SUM_W-1:0]   off;

   assign cnt_x  = deq_pkg::CMP_W'(count_ff);
   assign pos_x  = deq_pkg::CMP_W'(req.position);
   assign k_x    = deq_pkg::CMP_W'(req.remove_count);
   assign full   = (count_ff == deq_pkg::COUNT_W'(deq_pkg::DEPTH));
   assign empty  = (count_ff == '0);
   assign pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
   assign k_eff  = (k_x > cnt_x) ? count_ff : deq_pkg::COUNT_W'(req.remove_count);

   always_comb begin
      front_in            = front_ff;
      count_in            = count_ff;
      mem_wr_en           = 1'b0;
      off                 = '0;
      rsp_ctl_in.valid    = accept;
      rsp_ctl_in.from_mem = 1'b0;
      rsp_ctl_in.status   = deq_pkg::ST_OK;

      case (req.opcode)
         deq_pkg::OP_PUSH_REAR: begin
            off = deq_pkg::SUM_W'(count_ff);
            if (full) begin
               rsp_ctl_in.status = deq_pkg::ST_FULL;
            end else begin
               mem_wr_en = accept;
               count_in  = count_ff + 1'b1;
            end
         end
         deq_pkg::OP_PUSH_FRONT: begin
            off = deq_pkg::SUM_W'(deq_pkg::DEPTH - 1);
            if (full) begin
               rsp_ctl_in.status = deq_pkg::ST_FULL;
            end else begin
               mem_wr_en = accept;
               front_in  = deq_pkg::ring_add(front_ff, off);
               count_in  = count_ff + 1'b1;
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            off = '0;
            if (empty) begin
               rsp_ctl_in.status = deq_pkg::ST_EMPTY;
            end else begin
               rsp_ctl_in.from_mem = 1'b1;
               front_in = deq_pkg::ring_add(front_ff, deq_pkg::SUM_W'(1));
               count_in = count_ff - 1'b1;
            end
         end
         deq_pkg::OP_POP_REAR: begin
            off = deq_pkg::SUM_W'(count_ff - 1'b1);
            if (empty) begin
               rsp_ctl_in.status = deq_pkg::ST_EMPTY;
            end else begin
               rsp_ctl_in.from_mem = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         deq_pkg::OP_READ_POS: begin
            off = deq_pkg::SUM_W'(pos_x - 1'b1);
            if (pos_ok) begin
               rsp_ctl_in.from_mem = 1'b1;
            end else begin
               rsp_ctl_in.status = deq_pkg::ST_EMPTY;
            end
         end
         deq_pkg::OP_DROP: begin
            off      = deq_pkg::SUM_W'(k_eff);
            front_in = deq_pkg::ring_add(front_ff, off);
            count_in = count_ff - k_eff;
         end
         default: begin
            off = '0;
         end
      endcase

      rsp_ctl_in.fill = deq_pkg::FIELD_W'(count_in);
      if (!accept) begin
         front_in = front_ff;
         count_in = count_ff;
      end
   end

   // push front writes at the new front, every other access at front + off
   assign mem_addr    = (req.opcode == deq_pkg::OP_PUSH_FRONT) ? front_in
                                                               : deq_pkg::ring_add(front_ff, off);
   assign mem_wr_data = deq_pkg::to_word(req.value);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff         <= '0;
         count_ff         <= '0;
         rsp_ctl_ff.valid <= 1'b0;
      end else begin
         front_ff         <= front_in;
         count_ff         <= count_in;
         rsp_ctl_ff.valid <= rsp_ctl_in.valid;
      end
      rsp_ctl_ff.from_mem <= rsp_ctl_in.from_mem;
      rsp_ctl_ff.status   <= rsp_ctl_in.status;
      rsp_ctl_ff.fill     <= rsp_ctl_in.fill;
   end

   assign rsp_ctl = rsp_ctl_ff;

endmodule

// ===== rtl/deq_resp.sv =====
// ----------------------------------------------------------------------------
// deq_resp
// Result stage: merges RAM read data with the registered status.
// ----------------------------------------------------------------------------
module deq_resp (
   input  deq_pkg::rsp_ctl_type            rsp_ctl,
   input  logic [deq_pkg::DATA_WIDTH-1:0]  mem_rd_data,
   output logic                            rsp_valid,
   output deq_pkg::rsp_type                rsp_payload
);

   always_comb begin
      rsp_valid                = rsp_ctl.valid;
      rsp_payload.status       = rsp_ctl.status;
      rsp_payload.fill_level   = rsp_ctl.fill;
      if (rsp_ctl.from_mem) begin
         rsp_payload.result_value = deq_pkg::from_word(mem_rd_data);
      end else if (rsp_ctl.status == deq_pkg::ST_OK) begin
         rsp_payload.result_value = '0;
      end else begin
         rsp_payload.result_value = '1;   // -1 on empty / not found / full
      end
   end

endmodule

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue held in a ring buffer in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request beat: req_payload (opcode, value, position, remove_count) is
//   taken on a rising edge with start high and busy low. busy stays low, so
//   a new request may be issued every cycle.
//   Result beat: exactly one per request, on rsp_payload with rsp_valid high
//   for one cycle, in the cycle after the request edge (throughput one
//   request per cycle). Results come out in request order.
//   Every request does at most one RAM access (write for push, read for pop
//   and positional read). Front index and count update at the request edge,
//   so a following request always sees the new state; a read of an entry
//   written the cycle before finds it already in the array.
//   Reset (synchronous, active high) empties the queue; stored words are not
//   cleared, since an entry is only read after it has been written.
//   The receiver cannot stall: each result is valid for its one cycle only.
// ----------------------------------------------------------------------------
module double_ended_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  deq_pkg::req_type  req_payload,
   output logic              rsp_valid,
   output deq_pkg::rsp_type  rsp_payload
);

   logic                           accept;
   logic                           mem_wr_en;
   logic [deq_pkg::ADDR_W-1:0]     mem_addr;
   logic [deq_pkg::DATA_WIDTH-1:0] mem_wr_data;
   logic [deq_pkg::DATA_WIDTH-1:0] mem_rd_data;
   deq_pkg::rsp_ctl_type           rsp_ctl;

   // one access per beat and no multi-cycle work, so no back-pressure
   assign busy   = 1'b0;
   assign accept = start && !busy;

   deq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_payload),
      .mem_wr_en   (mem_wr_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .rsp_ctl     (rsp_ctl)
   );

   // entry store: write on push, read on pop / positional read
   deq_ram #(
      .WORDS  (deq_pkg::DEPTH),
      .DATA_W (deq_pkg::DATA_WIDTH),
      .ADDR_W (deq_pkg::ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   deq_resp u_resp (
      .rsp_ctl     (rsp_ctl),
      .mem_rd_data (mem_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/double_ended_queue_check.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_check
// Port-level checks for the deque, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module double_ended_queue_check (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input deq_pkg::rsp_type  rsp_payload
);

   // a result beat only follows a request beat
   `DEQ_ASSERT_IMPLY(a_rsp_follows_req, clock, reset, rsp_valid, $past(start && !busy))

   // every request beat gives a result beat next cycle
   `DEQ_ASSERT_NEXT(a_req_gives_rsp, clock, reset, start && !busy, rsp_valid)

   // failed requests report -1
   `DEQ_ASSERT_IMPLY(a_fail_value, clock, reset,
      rsp_valid && (rsp_payload.status != deq_pkg::ST_OK), rsp_payload.result_value == -32'sd1)

   // a failed request leaves the fill level alone
   `DEQ_ASSERT_IMPLY(a_fail_keeps_fill, clock, reset,
      rsp_valid && $past(rsp_valid) && (rsp_payload.status != deq_pkg::ST_OK),
      rsp_payload.fill_level == $past(rsp_payload.fill_level))

endmodule

bind double_ended_queue double_ended_queue_check u_check (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ring-buffer deque. A directed script covers the
// empty and full corners, every opcode and the out-of-range reads, then a
// random stream with alternating push-heavy and pop-heavy tides runs under
// three sender idling profiles. Every result beat is compared field by field
// with the script row's expected result or with a shadow deque kept in the bench.
// ----------------------------------------------------------------------------
module testbench;

   localparam int LIMIT_CYCLES = 200000;
   localparam int RANDOM_ITEMS = 150;
   localparam logic signed [31:0] NONE_VALUE = -32'sd1;

   // one line of the directed script; reps > 1 repeats the row with random data
   typedef struct {
      logic [2:0]         opcode;
      logic signed [31:0] value;
      logic [10:0]        position;
      logic [10:0]        remove_count;
      int                 reps;
      bit                 typed;
      deq_pkg::rsp_type   want;
   } script_row_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   deq_pkg::req_type req_payload;
   logic             rsp_valid;
   deq_pkg::rsp_type rsp_payload;

   double_ended_queue dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // shadow deque: the words, the front slot and the count
   logic [deq_pkg::DATA_WIDTH-1:0] shadow_store [deq_pkg::DEPTH];
   int                             shadow_front;
   int                             shadow_count;

   deq_pkg::rsp_type pending_rsp [$];   // results owed by the block, oldest first
   script_row_type   script [$];
   int               fail_count  = 0;
   int               cycle_count = 0;
   deq_pkg::rsp_type oldest;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = ~clock;
   end

   // watchdog: a hang or lost beat ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Next state and result of the deque for one request. Words are kept in
   // their low DATA_WIDTH bits and come back sign extended to 32 bits.
   task automatic deque_step(input deq_pkg::req_type r, output deq_pkg::rsp_type o);
      int slot;
      int k;
      o.result_value = '0;
      o.status       = deq_pkg::ST_OK;
      case (r.opcode)
         deq_pkg::OP_PUSH_REAR: begin
            if (shadow_count >= deq_pkg::DEPTH) begin
               o.result_value = NONE_VALUE;
               o.status       = deq_pkg::ST_FULL;
            end else begin
               slot = (shadow_front + shadow_count) % deq_pkg::DEPTH;
               shadow_store[slot] = deq_pkg::DATA_WIDTH'(unsigned'(r.value));
               shadow_count++;
            end
         end
         deq_pkg::OP_PUSH_FRONT: begin
            if (shadow_count >= deq_pkg::DEPTH) begin
               o.result_value = NONE_VALUE;
               o.status       = deq_pkg::ST_FULL;
            end else begin
               shadow_front = (shadow_front + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
               shadow_store[shadow_front] = deq_pkg::DATA_WIDTH'(unsigned'(r.value));
               shadow_count++;
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            if (shadow_count == 0) begin
               o.result_value = NONE_VALUE;
               o.status       = deq_pkg::ST_EMPTY;
            end else begin
               o.result_value = 32'(signed'(shadow_store[shadow_front]));
               shadow_front   = (shadow_front + 1) % deq_pkg::DEPTH;
               shadow_count--;
            end
         end
         deq_pkg::OP_POP_REAR: begin
            if (shadow_count == 0) begin
               o.result_value = NONE_VALUE;
               o.status       = deq_pkg::ST_EMPTY;
            end else begin
               slot = (shadow_front + shadow_count - 1) % deq_pkg::DEPTH;
               o.result_value = 32'(signed'(shadow_store[slot]));
               shadow_count--;
            end
         end
         deq_pkg::OP_READ_POS: begin
            if (r.position == 0 || int'(r.position) > shadow_count) begin
               o.result_value = NONE_VALUE;
               o.status       = deq_pkg::ST_EMPTY;
            end else begin
               slot = (shadow_front + int'(r.position) - 1) % deq_pkg::DEPTH;
               o.result_value = 32'(signed'(shadow_store[slot]));
            end
         end
         deq_pkg::OP_DROP: begin
            // dropping more than stored empties the deque, never an error
            k = int'(r.remove_count);
            if (k > shadow_count) begin
               k = shadow_count;
            end
            shadow_front = (shadow_front + k) % deq_pkg::DEPTH;
            shadow_count = shadow_count - k;
         end
         default: begin
            // codes six and seven leave the state alone
         end
      endcase
      o.fill_level = 11'(shadow_count);
   endtask

   function automatic script_row_type mk_row(input logic [2:0] op,
                                             input logic signed [31:0] v,
                                             input int pos, input int k, input int reps,
                                             input bit typed, input logic signed [31:0] rv,
                                             input logic [1:0] st, input int fill);
      script_row_type s;
      s.opcode            = op;
      s.value             = v;
      s.position          = 11'(pos);
      s.remove_count      = 11'(k);
      s.reps              = reps;
      s.typed             = typed;
      s.want.result_value = rv;
      s.want.status       = st;
      s.want.fill_level   = 11'(fill);
      return s;
   endfunction

   // Random request. Reads mostly hit a stored position and drops are mostly
   // short, so the deque keeps some depth; the rest sweeps the whole field.
   function automatic deq_pkg::req_type random_request(input bit push_tide);
      deq_pkg::req_type r;
      int               pick;
      r.opcode       = deq_pkg::OP_PUSH_REAR;
      r.value        = $urandom;
      r.position     = 11'($urandom_range(0, 2047));
      r.remove_count = 11'($urandom_range(0, 2047));
      pick = $urandom_range(0, 99);
      if (push_tide) begin
         if (pick < 30)      r.opcode = deq_pkg::OP_PUSH_REAR;
         else if (pick < 60) r.opcode = deq_pkg::OP_PUSH_FRONT;
         else if (pick < 68) r.opcode = deq_pkg::OP_POP_FRONT;
         else if (pick < 75) r.opcode = deq_pkg::OP_POP_REAR;
         else if (pick < 90) r.opcode = deq_pkg::OP_READ_POS;
         else if (pick < 95) r.opcode = deq_pkg::OP_DROP;
         else                r.opcode = 3'($urandom_range(6, 7));
      end else begin
         if (pick < 13)      r.opcode = deq_pkg::OP_PUSH_REAR;
         else if (pick < 25) r.opcode = deq_pkg::OP_PUSH_FRONT;
         else if (pick < 48) r.opcode = deq_pkg::OP_POP_FRONT;
         else if (pick < 70) r.opcode = deq_pkg::OP_POP_REAR;
         else if (pick < 85) r.opcode = deq_pkg::OP_READ_POS;
         else if (pick < 95) r.opcode = deq_pkg::OP_DROP;
         else                r.opcode = 3'($urandom_range(6, 7));
      end
      if (r.opcode == deq_pkg::OP_READ_POS && shadow_count > 0
          && $urandom_range(0, 9) < 8) begin
         r.position = 11'($urandom_range(1, shadow_count));
      end
      if (r.opcode == deq_pkg::OP_DROP && $urandom_range(0, 99) < 85) begin
         r.remove_count = 11'($urandom_range(0, 3));
      end
      return r;
   endfunction

   // Drive one request beat: idle first at the given rate, then hold start
   // until the edge that takes the beat. The shadow deque moves at that edge.
   task automatic send_request(input deq_pkg::req_type r, input int idle_pct,
                               input bit typed, input deq_pkg::rsp_type want);
      deq_pkg::rsp_type predicted;
      while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      do begin
         @(posedge clock);
      end while (busy);
      deque_step(r, predicted);
      pending_rsp.push_back(typed ? want : predicted);
   endtask

   function automatic void check_field(input string field, input longint want,
                                       input longint got);
      if (want != got) begin
         fail_count++;
         $display("%0t mismatch on %s: expected %0d actual %0d", $time, field, want, got);
      end
   endfunction

   // Result side: every beat is taken the cycle it shows up and matched
   // against the oldest owed result.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            fail_count++;
            $display("%0t unexpected result beat: expected none actual value %0d status %0d fill %0d",
                     $time, rsp_payload.result_value, rsp_payload.status,
                     rsp_payload.fill_level);
         end else begin
            oldest = pending_rsp.pop_front();
            check_field("result_value", longint'(oldest.result_value),
                        longint'(rsp_payload.result_value));
            check_field("status", longint'(oldest.status), longint'(rsp_payload.status));
            check_field("fill_level", longint'(oldest.fill_level),
                        longint'(rsp_payload.fill_level));
         end
      end
   end

   initial begin
      deq_pkg::req_type r;
      deq_pkg::rsp_type none;
      int               idle_profile [3];
      int               tide_left;
      bit               push_tide;

      reset        = 1'b1;
      start        = 1'b0;
      req_payload  = '0;
      shadow_front = 0;
      shadow_count = 0;
      none         = '0;
      idle_profile = '{20, 83, 0};

      // --- directed script, starting from the empty deque ---
      // empty deque: pops, reads, drops of none and of 2047, and the unused codes
      script.push_back(mk_row(deq_pkg::OP_POP_FRONT, 0, 0, 0, 1, 1,
                              NONE_VALUE, deq_pkg::ST_EMPTY, 0));
      script.push_back(mk_row(deq_pkg::OP_POP_REAR, 0, 0, 0, 1, 1,
                              NONE_VALUE, deq_pkg::ST_EMPTY, 0));
      script.push_back(mk_row(deq_pkg::OP_READ_POS, 0, 0, 0, 1, 1,
                              NONE_VALUE, deq_pkg::ST_EMPTY, 0));
      script.push_back(mk_row(deq_pkg::OP_READ_POS, 0, 1024, 0, 1, 1,
                              NONE_VALUE, deq_pkg::ST_EMPTY, 0));
      script.push_back(mk_row(deq_pkg::OP_DROP, 0, 0, 0, 1, 1, 0, deq_pkg::ST_OK, 0));
      script.push_back(mk_row(deq_pkg::OP_DROP, 0, 0, 2047, 1, 1, 0, deq_pkg::ST_OK, 0));
      script.push_back(mk_row(3'd6, -1, 2047, 2047, 1, 1, 0, deq_pkg::ST_OK, 0));
      script.push_back(mk_row(3'd7, -1, 2047, 2047, 1, 1, 0, deq_pkg::ST_OK, 0));
      // extreme words at both ends: front to rear reads 0, min, max, -1
      script.push_back(mk_row(deq_pkg::OP_PUSH_REAR, 32'sh7fffffff, 0, 0, 1, 1,
                              0, deq_pkg::ST_OK, 1));
      script.push_back(mk_row(deq_pkg::OP_PUSH_FRONT, 32'sh80000000, 0, 0, 1, 1,
                              0, deq_pkg::ST_OK, 2));
      script.push_back(mk_row(deq_pkg::OP_PUSH_REAR, -1, 0, 0, 1, 1, 0, deq_pkg::ST_OK, 3));
      script.push_back(mk_row(deq_pkg::OP_PUSH_FRONT, 0, 0, 0, 1, 1, 0, deq_pkg::ST_OK, 4));
      script.push_back(mk_row(deq_pkg::OP_READ_POS, 0, 1, 0, 1, 1, 0, deq_pkg::ST_OK, 4));
      script.push_back(mk_row(deq_pkg::OP_READ_POS, 0, 4, 0, 1, 1, -1, deq_pkg::ST_OK, 4));
      script.push_back(mk_row(deq_pkg::OP_READ_POS, 0, 5, 0, 1, 1,
                              NONE_VALUE, deq_pkg::ST_EMPTY, 4));
      script.push_back(mk_row(deq_pkg::OP_READ_POS, 0, 2047, 0, 1, 1,
                              NONE_VALUE, deq_pkg::ST_EMPTY, 4));
      script.push_back(mk_row(deq_pkg::OP_POP_FRONT, 0, 0, 0, 1, 1, 0, deq_pkg::ST_OK, 3));
      script.push_back(mk_row(deq_pkg::OP_POP_REAR, 0, 0, 0, 1, 1, -1, deq_pkg::ST_OK, 2));
      script.push_back(mk_row(deq_pkg::OP_READ_POS, 0, 2, 0, 1, 1,
                              32'sh7fffffff, deq_pkg::ST_OK, 2));
      script.push_back(mk_row(deq_pkg::OP_DROP, 0, 0, 1, 1, 1, 0, deq_pkg::ST_OK, 1));
      script.push_back(mk_row(deq_pkg::OP_POP_FRONT, 0, 0, 0, 1, 1,
                              32'sh7fffffff, deq_pkg::ST_OK, 0));
      // fill to the brim from both ends so the front wraps the ring
      script.push_back(mk_row(deq_pkg::OP_PUSH_FRONT, 0, 0, 0, deq_pkg::DEPTH / 2, 0,
                              0, deq_pkg::ST_OK, 0));
      script.push_back(mk_row(deq_pkg::OP_PUSH_REAR, 0, 0, 0, deq_pkg::DEPTH / 2, 0,
                              0, deq_pkg::ST_OK, 0));
      // full deque: pushes bounce, last slot readable, one past it is not
      script.push_back(mk_row(deq_pkg::OP_PUSH_REAR, 5, 0, 0, 1, 1,
                              NONE_VALUE, deq_pkg::ST_FULL, deq_pkg::DEPTH));
      script.push_back(mk_row(deq_pkg::OP_PUSH_FRONT, 5, 0, 0, 1, 1,
                              NONE_VALUE, deq_pkg::ST_FULL, deq_pkg::DEPTH));
      script.push_back(mk_row(deq_pkg::OP_READ_POS, 0, deq_pkg::DEPTH, 0, 1, 0,
                              0, deq_pkg::ST_OK, 0));
      script.push_back(mk_row(deq_pkg::OP_READ_POS, 0, deq_pkg::DEPTH + 1, 0, 1, 1,
                              NONE_VALUE, deq_pkg::ST_EMPTY, deq_pkg::DEPTH));
      script.push_back(mk_row(deq_pkg::OP_POP_REAR, 0, 0, 0, 1, 0, 0, deq_pkg::ST_OK, 0));
      script.push_back(mk_row(deq_pkg::OP_DROP, 0, 0, 2047, 1, 1, 0, deq_pkg::ST_OK, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         for (int n = 0; n < script[i].reps; n++) begin
            r.opcode       = script[i].opcode;
            r.value        = (script[i].reps > 1) ? signed'($urandom) : script[i].value;
            r.position     = script[i].position;
            r.remove_count = script[i].remove_count;
            send_request(r, 0, script[i].typed, script[i].want);
         end
      end

      // --- random stream: light idling, heavy idling, back to back ---
      tide_left = 0;
      push_tide = 1'b1;
      foreach (idle_profile[p]) begin
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            if (tide_left == 0) begin
               push_tide = ~push_tide;
               tide_left = $urandom_range(20, 200);
            end
            tide_left--;
            r = random_request(push_tide);
            send_request(r, idle_profile[p], 1'b0, none);
         end
      end
      start <= 1'b0;

      // drain, then give any stray beat time to show up
      while (pending_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
